// ===== rtl/rrt_pkg.sv =====
// package for the request retry tracker: types and constants
package rrt_pkg;
  localparam int SLOTS = 16;
  localparam int OWNERS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int QDEPTH = 2;

  localparam logic [2:0] MODE_REQ = 3'd0;
  localparam logic [2:0] MODE_TICK = 3'd1;
  localparam logic [2:0] MODE_ACK = 3'd2;
  localparam logic [2:0] MODE_DOWN = 3'd3;
  localparam logic [2:0] MODE_GONE = 3'd4;

  localparam logic [2:0] KIND_REFUSED = 3'd0;
  localparam logic [2:0] KIND_FIRST = 3'd1;
  localparam logic [2:0] KIND_RESEND = 3'd2;
  localparam logic [2:0] KIND_FAILED = 3'd3;
  localparam logic [2:0] KIND_MATCHED = 3'd4;
  localparam logic [2:0] KIND_UNMATCHED = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [31:0] node_addr;
    logic [31:0] ack_id;
    logic [3:0] owner_num;
    logic [31:0] period_us;
    logic [7:0] send_limit;
    logic node_known;
    logic [63:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot_num;
    logic [31:0] dest_node;
    logic [31:0] req_id;
    logic [3:0] owner_out;
    logic last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic refuse;
    in_item_t item;
  } cmd_t;
endpackage

// ===== rtl/request_retry_tracker_core.sv =====
// top level of the request retry tracker
//  channel | handshake     | beat
//  in      | valid / stall | in_item_t
//  out     | valid / stall | out_item_t
//  cfg     | valid / ready | broadcast node address
// a request is served in idle; tick, ack, node-down and owner-gone walk
// the slot table one slot per cycle in the back end while not stalled
// reset clears the slot used bits, time, id counter and queue at once
// a two-entry command queue lets the front accept while the back is busy
// an output stall while a result is held back stops the scan on its slot
module request_retry_tracker_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  rrt_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rrt_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [31:0] cfg_data
);
  logic [31:0] bcast_addr;
  logic cmd_valid, cmd_take;
  rrt_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bcast_addr <= 32'hFFFF_FFFF;
    else if (cfg_valid) bcast_addr <= cfg_data;
  end

  rrt_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .bcast_addr,
    .cmd_valid, .cmd_take, .cmd
  );

  rrt_back u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd, .out_valid, .out_stall, .out_data
  );
endmodule

// ===== rtl/rrt_front.sv =====
// front end: accepts input beats, classifies them, queues commands
module rrt_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  rrt_pkg::in_item_t in_data,
  input  logic [31:0] bcast_addr,
  output logic cmd_valid,
  input  logic cmd_take,
  output rrt_pkg::cmd_t cmd
);
  localparam int QW = $clog2(rrt_pkg::QDEPTH);
  rrt_pkg::cmd_t q [rrt_pkg::QDEPTH];
  logic [QW-1:0] wp, rp;
  logic [QW:0] cnt;
  logic push, pop;
  rrt_pkg::cmd_t c;

  assign in_stall = (cnt == (QW+1)'(rrt_pkg::QDEPTH));
  assign push = in_valid && !in_stall;
  assign pop = cmd_take && cmd_valid;
  assign cmd_valid = (cnt != '0);
  assign cmd = q[rp];

  always_comb begin
    c.item = in_data;
    c.refuse = (in_data.node_addr == bcast_addr) || !in_data.node_known ||
               ({28'd0, in_data.owner_num} >= 32'(rrt_pkg::OWNERS));
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= c;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QW+1)'(push) - (QW+1)'(pop);
    end
  end
endmodule

// ===== rtl/rrt_back.sv =====
// back end: slot table, one slot visited per cycle for scans while no output stall holds them
module rrt_back (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_take,
  input  rrt_pkg::cmd_t cmd,
  output logic out_valid,
  input  logic out_stall,
  output rrt_pkg::out_item_t out_data
);
  localparam int SW = rrt_pkg::SLOT_W;
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state;
  logic [rrt_pkg::SLOTS-1:0] used;
  logic [31:0] s_dest [rrt_pkg::SLOTS];
  logic [31:0] s_id [rrt_pkg::SLOTS];
  logic [3:0] s_owner [rrt_pkg::SLOTS];
  logic [31:0] s_period [rrt_pkg::SLOTS];
  logic [7:0] s_limit [rrt_pkg::SLOTS];
  logic [7:0] s_sends [rrt_pkg::SLOTS];
  logic [63:0] s_time [rrt_pkg::SLOTS];
  logic [63:0] last_time;
  logic [31:0] id_counter;
  rrt_pkg::in_item_t cur;
  logic [SW:0] idx;
  logic [SW-1:0] si;
  logic any;
  // one result held back so that last can be set on it
  logic pend_v;
  rrt_pkg::out_item_t pend;

  logic free_found;
  logic [SW-1:0] free_idx;
  logic [31:0] id_next;
  logic hit, due, can_emit, out_free;
  logic [63:0] el;
  rrt_pkg::out_item_t res;

  assign si = idx[SW-1:0];
  assign out_free = !out_valid || !out_stall;
  // a new result may be emitted if the hold slot is empty or can move to output
  assign can_emit = !pend_v || out_free;
  assign cmd_take = (state == S_IDLE) && cmd_valid && !pend_v && out_free;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = rrt_pkg::SLOTS-1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx = SW'(i);
      end
    end
    id_next = (id_counter + 32'd1 == 32'd0) ? 32'd1 : id_counter + 32'd1;
  end

  always_comb begin
    el = cur.now_us - s_time[si];
    due = el >= {32'd0, s_period[si]};
    res.kind = rrt_pkg::KIND_FAILED;
    res.slot_num = 4'(si);
    res.dest_node = s_dest[si];
    res.req_id = s_id[si];
    res.owner_out = s_owner[si];
    res.last = 1'b0;
    hit = 1'b0;
    unique case (cur.mode)
      rrt_pkg::MODE_TICK: begin
        hit = used[si] && due;
        if (s_sends[si] < s_limit[si]) res.kind = rrt_pkg::KIND_RESEND;
      end
      rrt_pkg::MODE_ACK: begin
        hit = used[si] && s_dest[si] == cur.node_addr && s_id[si] == cur.ack_id;
        res.kind = rrt_pkg::KIND_MATCHED;
      end
      rrt_pkg::MODE_DOWN: hit = used[si] && s_dest[si] == cur.node_addr;
      rrt_pkg::MODE_GONE: hit = used[si] && s_owner[si] == cur.owner_num;
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      last_time <= '0;
      id_counter <= '0;
      pend_v <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
      any <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            cur <= cmd.item;
            idx <= '0;
            any <= 1'b0;
            if (cmd.item.mode == rrt_pkg::MODE_REQ) begin
              out_valid <= 1'b1;
              out_data.last <= 1'b1;
              out_data.dest_node <= cmd.item.node_addr;
              if (cmd.refuse || !free_found) begin
                out_data.kind <= rrt_pkg::KIND_REFUSED;
                out_data.slot_num <= '0;
                out_data.req_id <= '0;
                out_data.owner_out <= '0;
              end else begin
                used[free_idx] <= 1'b1;
                s_dest[free_idx] <= cmd.item.node_addr;
                s_id[free_idx] <= id_next;
                s_owner[free_idx] <= cmd.item.owner_num;
                s_period[free_idx] <= cmd.item.period_us;
                s_limit[free_idx] <= cmd.item.send_limit;
                s_sends[free_idx] <= 8'd1;
                s_time[free_idx] <= last_time;
                id_counter <= id_next;
                out_data.kind <= rrt_pkg::KIND_FIRST;
                out_data.slot_num <= 4'(free_idx);
                out_data.req_id <= id_next;
                out_data.owner_out <= cmd.item.owner_num;
              end
            end else if (cmd.item.mode <= rrt_pkg::MODE_GONE) begin
              if (cmd.item.mode == rrt_pkg::MODE_TICK) last_time <= cmd.item.now_us;
              state <= S_SCAN;
            end
          end else if (pend_v && out_free) begin
            out_valid <= 1'b1;
            out_data <= pend;
            pend_v <= 1'b0;
          end
        end
        S_SCAN: begin
          if (can_emit) begin
            if (hit) begin
              if (cur.mode == rrt_pkg::MODE_TICK && res.kind == rrt_pkg::KIND_RESEND) begin
                s_sends[si] <= s_sends[si] + 8'd1;
                s_time[si] <= cur.now_us;
              end else begin
                used[si] <= 1'b0;
              end
              if (cur.mode != rrt_pkg::MODE_GONE) begin
                any <= 1'b1;
                pend <= res;
                pend_v <= 1'b1;
                if (pend_v) begin
                  out_valid <= 1'b1;
                  out_data <= pend;
                end
              end
            end
            if (idx == (SW+1)'(rrt_pkg::SLOTS-1) ||
                (hit && cur.mode == rrt_pkg::MODE_ACK))
              state <= S_FIN;
            else idx <= idx + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
            if (pend_v) begin
              out_valid <= 1'b1;
              out_data <= pend;
              out_data.last <= 1'b1;
              pend_v <= 1'b0;
            end else if (cur.mode == rrt_pkg::MODE_ACK && !any) begin
              out_valid <= 1'b1;
              out_data.kind <= rrt_pkg::KIND_UNMATCHED;
              out_data.slot_num <= '0;
              out_data.dest_node <= cur.node_addr;
              out_data.req_id <= cur.ack_id;
              out_data.owner_out <= '0;
              out_data.last <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/request_retry_tracker_core_checker.sv =====
// checker for the request retry tracker: predicts slot table results and compares
module request_retry_tracker_core_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  rrt_pkg::in_item_t in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  rrt_pkg::out_item_t out_data,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [31:0] cfg_data,
  output int fails,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] bcast;
  logic        used [rrt_pkg::SLOTS];
  logic [31:0] dest [rrt_pkg::SLOTS];
  logic [31:0] rid [rrt_pkg::SLOTS];
  logic [3:0]  owner [rrt_pkg::SLOTS];
  logic [31:0] period [rrt_pkg::SLOTS];
  logic [7:0]  limit [rrt_pkg::SLOTS];
  logic [7:0]  sends [rrt_pkg::SLOTS];
  logic [63:0] sent_at [rrt_pkg::SLOTS];
  logic [63:0] cur_time;
  logic [31:0] next_id;
  rrt_pkg::out_item_t results_due [$];

  assign pending = results_due.size();

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fails++;
  endtask

  function automatic rrt_pkg::out_item_t mk(logic [2:0] k, logic [3:0] s, logic [31:0] d,
                                            logic [31:0] i, logic [3:0] o);
    rrt_pkg::out_item_t r;
    r.kind = k;
    r.slot_num = s;
    r.dest_node = d;
    r.req_id = i;
    r.owner_out = o;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic track(rrt_pkg::in_item_t it);
    rrt_pkg::out_item_t outs [$];
    int free_slot;
    bit hit;
    free_slot = -1;
    hit = 0;
    case (it.mode)
      rrt_pkg::MODE_REQ: begin
        if (it.node_addr != bcast && it.node_known && it.owner_num < rrt_pkg::OWNERS)
          for (int i = 0; i < rrt_pkg::SLOTS; i++)
            if (!used[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          outs.push_back(mk(rrt_pkg::KIND_REFUSED, 4'd0, it.node_addr, 32'd0, 4'd0));
        end else begin
          next_id = next_id + 32'd1;
          if (next_id == 0) next_id = 32'd1;
          used[free_slot] = 1;
          dest[free_slot] = it.node_addr;
          rid[free_slot] = next_id;
          owner[free_slot] = it.owner_num;
          period[free_slot] = it.period_us;
          limit[free_slot] = it.send_limit;
          sends[free_slot] = 8'd1;
          sent_at[free_slot] = cur_time;
          outs.push_back(mk(rrt_pkg::KIND_FIRST, 4'(free_slot), it.node_addr, next_id,
                            it.owner_num));
        end
      end
      rrt_pkg::MODE_TICK: begin
        cur_time = it.now_us;
        for (int i = 0; i < rrt_pkg::SLOTS; i++) begin
          if (used[i] && (it.now_us - sent_at[i]) >= {32'd0, period[i]}) begin
            if (sends[i] < limit[i]) begin
              sends[i] = sends[i] + 8'd1;
              sent_at[i] = it.now_us;
              outs.push_back(mk(rrt_pkg::KIND_RESEND, 4'(i), dest[i], rid[i], owner[i]));
            end else begin
              used[i] = 0;
              outs.push_back(mk(rrt_pkg::KIND_FAILED, 4'(i), dest[i], rid[i], owner[i]));
            end
          end
        end
      end
      rrt_pkg::MODE_ACK: begin
        for (int i = 0; i < rrt_pkg::SLOTS; i++)
          if (!hit && used[i] && dest[i] == it.node_addr && rid[i] == it.ack_id) begin
            hit = 1;
            used[i] = 0;
            outs.push_back(mk(rrt_pkg::KIND_MATCHED, 4'(i), dest[i], rid[i], owner[i]));
          end
        if (!hit)
          outs.push_back(mk(rrt_pkg::KIND_UNMATCHED, 4'd0, it.node_addr, it.ack_id, 4'd0));
      end
      rrt_pkg::MODE_DOWN: begin
        for (int i = 0; i < rrt_pkg::SLOTS; i++)
          if (used[i] && dest[i] == it.node_addr) begin
            used[i] = 0;
            outs.push_back(mk(rrt_pkg::KIND_FAILED, 4'(i), it.node_addr, rid[i], owner[i]));
          end
      end
      rrt_pkg::MODE_GONE: begin
        for (int i = 0; i < rrt_pkg::SLOTS; i++)
          if (used[i] && owner[i] == it.owner_num) used[i] = 0;
      end
      default: ;
    endcase
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[k]) results_due.push_back(outs[k]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bcast = '1;
      for (int i = 0; i < rrt_pkg::SLOTS; i++) used[i] = 0;
      cur_time = 0;
      next_id = 0;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) bcast = cfg_data;
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report($sformatf("unexpected beat kind %0d slot %0d", out_data.kind,
                           out_data.slot_num));
        end else begin
          rrt_pkg::out_item_t e;
          e = results_due.pop_front();
          if (out_data.kind !== e.kind)
            report($sformatf("kind %0d, want %0d", out_data.kind, e.kind));
          if (out_data.slot_num !== e.slot_num)
            report($sformatf("slot %0d, want %0d", out_data.slot_num, e.slot_num));
          if (out_data.dest_node !== e.dest_node)
            report($sformatf("dest %h, want %h", out_data.dest_node, e.dest_node));
          if (out_data.req_id !== e.req_id)
            report($sformatf("id %h, want %h", out_data.req_id, e.req_id));
          if (out_data.owner_out !== e.owner_out)
            report($sformatf("owner %0d, want %0d", out_data.owner_out, e.owner_out));
          if (out_data.last !== e.last)
            report($sformatf("last %0b, want %0b", out_data.last, e.last));
        end
      end
      if (in_valid && !in_stall) track(in_data);
    end
  end
endmodule

// ===== tb/request_retry_tracker_core_tb.sv =====
// top of the request retry tracker testbench: stimulus, clock, reset and verdict
module request_retry_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  rrt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  rrt_pkg::out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  int fails;
  int pending;

  logic in_acc = 0, cfg_acc = 0;
  logic out_acc = 0;
  rrt_pkg::out_item_t out_seen;
  logic hold = 0;
  int stall_cnt = 0;
  event hold_go;
  logic [63:0] tbase = 0;
  logic [31:0] node_pool [6] = '{32'd0, 32'd1, 32'd7, 32'h8000_0000,
                                 32'hFFFF_FFFE, 32'hFFFF_FFFF};
  logic [31:0] live_dest [$];
  logic [31:0] live_id [$];

  request_retry_tracker_core dut (.*);
  request_retry_tracker_core_checker chk (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    in_acc <= in_valid && !in_stall;
    cfg_acc <= cfg_valid && cfg_ready;
    out_acc <= out_valid && !out_stall;
    out_seen <= out_data;
  end

  // remember issued ids so acks can hit live slots
  always @(negedge clk)
    if (out_acc && out_seen.kind == rrt_pkg::KIND_FIRST) begin
      live_dest.push_back(out_seen.dest_node);
      live_id.push_back(out_seen.req_id);
      if (live_id.size() > 24) begin
        void'(live_dest.pop_front());
        void'(live_id.pop_front());
      end
    end

  initial forever begin
    @(hold_go);
    hold = 1;
    repeat (220) @(negedge clk);
    hold = 0;
  end

  // receiver pattern: free running, light stall, heavy stall; the hold flag stalls in every phase
  always @(negedge clk) begin
    stall_cnt++;
    case ((stall_cnt / 90) % 3)
      0: out_stall = hold;
      1: out_stall = hold || ($urandom_range(0, 3) == 0);
      default: out_stall = hold || ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic rrt_pkg::in_item_t mk(logic [2:0] m, logic [31:0] n, logic [31:0] a,
                                           logic [3:0] o, logic [31:0] p, logic [7:0] l,
                                           logic k, logic [63:0] t);
    rrt_pkg::in_item_t r;
    r.mode = m; r.node_addr = n; r.ack_id = a; r.owner_num = o;
    r.period_us = p; r.send_limit = l; r.node_known = k; r.now_us = t;
    return r;
  endfunction

  task automatic send(rrt_pkg::in_item_t it, int gap);
    in_data = it;
    in_valid = 1;
    do @(negedge clk); while (!in_acc);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // idle wait; queued scans that emit nothing still need their slot walks
  task automatic drain();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (4 * rrt_pkg::SLOTS + 16) @(negedge clk);
  endtask

  task automatic write_bcast(logic [31:0] v);
    cfg_data = v;
    cfg_valid = 1;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid = 0;
  endtask

  function automatic rrt_pkg::in_item_t rand_item();
    int r;
    logic [31:0] n, a;
    r = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom : node_pool[$urandom_range(0, 5)];
    a = $urandom;
    if (r < 40)
      return mk(rrt_pkg::MODE_REQ, n, $urandom, 4'($urandom),
                ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60),
                ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
                $urandom_range(0, 9) != 0, {$urandom, $urandom});
    if (r < 65) begin
      if ($urandom_range(0, 19) == 0) tbase = {$urandom, $urandom};
      else tbase = tbase + $urandom_range(0, 30);
      return mk(rrt_pkg::MODE_TICK, $urandom, $urandom, 4'($urandom), $urandom,
                8'($urandom), 1'($urandom), tbase);
    end
    if (r < 85) begin
      if (live_id.size() > 0 && $urandom_range(0, 3) != 0) begin
        int k;
        k = $urandom_range(0, live_id.size() - 1);
        n = live_dest[k];
        a = live_id[k];
      end
      return mk(rrt_pkg::MODE_ACK, n, a, 4'($urandom), $urandom, 8'($urandom),
                1'($urandom), {$urandom, $urandom});
    end
    if (r < 92)
      return mk(rrt_pkg::MODE_DOWN, n, $urandom, 4'($urandom), $urandom, 8'($urandom),
                1'($urandom), {$urandom, $urandom});
    if (r < 97)
      return mk(rrt_pkg::MODE_GONE, $urandom, $urandom, 4'($urandom), $urandom,
                8'($urandom), 1'($urandom), {$urandom, $urandom});
    return mk(3'($urandom_range(5, 7)), $urandom, $urandom, 4'($urandom), $urandom,
              8'($urandom), 1'($urandom), {$urandom, $urandom});
  endfunction

  initial begin
    #5_000_000;
    $display("FAIL request_retry_tracker_core");
    $finish;
  end

  initial begin
    logic [31:0] bvals [4];
    int burst;
    bvals = '{32'd0, 32'd7, $urandom, 32'hFFFF_FFFF};
    repeat (7) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // broadcast, unknown node, zero limit, retry then fail
    send(mk(rrt_pkg::MODE_REQ, 32'hFFFF_FFFF, 0, 1, 5, 3, 1, 0), 1);
    send(mk(rrt_pkg::MODE_REQ, 32'd9, 0, 2, 5, 3, 0, 0), 0);
    send(mk(rrt_pkg::MODE_REQ, 32'd0, 0, 15, 0, 0, 1, 0), 2);
    send(mk(rrt_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 64'd5), 0);
    send(mk(rrt_pkg::MODE_REQ, 32'd7, 0, 3, 10, 2, 1, 0), 1);
    send(mk(rrt_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 64'd10), 0);
    send(mk(rrt_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 64'd15), 3);
    send(mk(rrt_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 64'd25), 0);
    send(mk(rrt_pkg::MODE_ACK, 32'd7, 32'h1234_5678, 0, 0, 0, 0, 0), 0);
    // ack on the oldest issued id, whose slot has already failed, node down on two slots, owner gone
    send(mk(rrt_pkg::MODE_REQ, 32'h8000_0000, 0, 4, 32'hFFFF_FFFF, 8'hFF, 1, 0), 0);
    send(mk(rrt_pkg::MODE_REQ, 32'd1, 0, 5, 32'hFFFF_FFFF, 8'hFF, 1, 0), 0);
    send(mk(rrt_pkg::MODE_REQ, 32'd1, 0, 6, 32'hFFFF_FFFF, 8'hFF, 1, 0), 0);
    send(mk(rrt_pkg::MODE_REQ, 32'd0, 0, 6, 32'hFFFF_FFFF, 8'hFF, 1, 0), 0);
    drain();
    send(mk(rrt_pkg::MODE_ACK, live_dest[0], live_id[0], 0, 0, 0, 0, 0), 0);
    send(mk(rrt_pkg::MODE_DOWN, 32'd1, 0, 0, 0, 0, 0, 0), 0);
    send(mk(rrt_pkg::MODE_GONE, 0, 0, 6, 0, 0, 0, 0), 0);
    send(mk(3'd5, 0, 0, 0, 0, 0, 0, 0), 0);
    send(mk(3'd7, '1, '1, '1, '1, '1, 1, '1), 0);
    // elapsed time across the 64-bit wrap
    send(mk(rrt_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0), 0);
    send(mk(rrt_pkg::MODE_REQ, 32'd2, 0, 0, 32'h15, 1, 1, 0), 0);
    send(mk(rrt_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 64'd5), 0);
    send(mk(rrt_pkg::MODE_GONE, 0, 0, 4, 0, 0, 0, 0), 0);
    tbase = 64'd100;

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_bcast(bvals[ph]);
      burst = 0;
      for (int i = 0; i < 57; i++) begin
        if (ph == 2 && i == 20) begin
          // fill some slots, then keep ticking against a held receiver
          for (int j = 0; j < 8; j++)
            send(mk(rrt_pkg::MODE_REQ, node_pool[j % 3], 0, 4'(j), 1, 3, 1, 0), 0);
          -> hold_go;
          for (int j = 0; j < 12; j++) begin
            tbase = tbase + 2;
            send(mk(rrt_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, tbase), 0);
          end
        end
        if (burst == 0) burst = $urandom_range(1, 12);
        burst--;
        send(rand_item(), (burst == 0) ? $urandom_range(1, 8) : 0);
      end
    end
    drain();
    if (fails == 0)
      $display("PASS request_retry_tracker_core");
    else
      $display("FAIL request_retry_tracker_core");
    $finish;
  end
endmodule

// ===== request_retry_tracker_core.f =====
rtl/rrt_pkg.sv
rtl/rrt_front.sv
rtl/rrt_back.sv
rtl/request_retry_tracker_core.sv
tb/request_retry_tracker_core_checker.sv
tb/request_retry_tracker_core_tb.sv
